FILE: design/ipm_pkg.sv
// shared constants, command codes and control structs for the ground point mapper
package ipm_pkg;

   localparam int COORD_BITS = 12;
   localparam int COEF_W     = 32;
   localparam int MUL_B_W    = 25;
   localparam int PROD_W     = COEF_W + MUL_B_W;
   localparam int ACC_W      = 46;
   localparam int OUT_W      = 24;
   localparam int QUOT_W     = 25;
   localparam int DIV_PRE    = QUOT_W - 16;
   localparam int STEP_W     = 4;
   localparam int SQ_W       = 48;
   localparam int LIM_W      = 46;
   localparam int CNT_W      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_COEF_A   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_B   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_C   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_D   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_L   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SKY      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_STEPS    = 3'd7;

   typedef logic [3:0] op_type;
   localparam op_type OP_NONE    = 4'd0;
   localparam op_type OP_LOAD    = 4'd1;
   localparam op_type OP_MOD     = 4'd2;
   localparam op_type OP_SKYSET  = 4'd3;
   localparam op_type OP_MUL     = 4'd4;
   localparam op_type OP_DIVINIT = 4'd5;
   localparam op_type OP_DIV     = 4'd6;
   localparam op_type OP_DIVEND  = 4'd7;
   localparam op_type OP_SQ      = 4'd8;
   localparam op_type OP_EMIT    = 4'd9;

   typedef struct packed {
      op_type     op;
      logic [2:0] idx;
      logic       sel_y;
   } cmd_type;

   typedef struct packed {
      logic on_grid;
      logic sky_hit;
      logic is_sky;
      logic w_zero;
      logic quot_bad;
      logic dist_ok;
      logic out_busy;
   } stat_type;

endpackage

FILE: design/ipm_ifs.sv
// valid/ready channel interfaces for pixel, ground point and register write words
interface ipm_req_if;
   logic                               valid;
   logic                               ready;
   logic [ipm_pkg::COORD_BITS-1:0]     pix_row;
   logic [ipm_pkg::COORD_BITS-1:0]     pix_col;
   logic [7:0]                         pix_blue;
   logic [7:0]                         pix_green;
   logic [7:0]                         pix_red;
   modport source (output valid, pix_row, pix_col, pix_blue, pix_green, pix_red,
                   input ready);
   modport sink   (input valid, pix_row, pix_col, pix_blue, pix_green, pix_red,
                   output ready);
endinterface

interface ipm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ipm_pkg::OUT_W-1:0]   ground_x;
   logic signed [ipm_pkg::OUT_W-1:0]   ground_y;
   logic [7:0]                         out_red;
   logic [7:0]                         out_green;
   logic [7:0]                         out_blue;
   modport source (output valid, ground_x, ground_y, out_red, out_green, out_blue,
                   input ready);
   modport sink   (input valid, ground_x, ground_y, out_red, out_green, out_blue,
                   output ready);
endinterface

interface ipm_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ipm_pkg::CSR_IDX_W-1:0]      index;
   logic [ipm_pkg::CSR_DATA_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/ipm_datapath.sv
// registers, multiplier, divider and compare logic of the ground point mapper
module ipm_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ipm_pkg::cmd_type                   cmd,
   output ipm_pkg::stat_type                  stat,
   input  logic [ipm_pkg::COORD_BITS-1:0]     pix_row,
   input  logic [ipm_pkg::COORD_BITS-1:0]     pix_col,
   input  logic [7:0]                         pix_blue,
   input  logic [7:0]                         pix_green,
   input  logic [7:0]                         pix_red,
   input  logic                               csr_valid,
   input  logic [ipm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ipm_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ipm_pkg::OUT_W-1:0]   rsp_ground_x,
   output logic signed [ipm_pkg::OUT_W-1:0]   rsp_ground_y,
   output logic [7:0]                         rsp_red,
   output logic [7:0]                         rsp_green,
   output logic [7:0]                         rsp_blue
);
   import ipm_pkg::*;

   // configuration
   logic [63:0]  coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic [31:0]  coef_l_ff;
   logic [7:0]   sky_ff;
   logic [22:0]  range_ff;
   logic [7:0]   steps_ff;

   // pixel and stream state
   logic [COORD_BITS-1:0] last_row_ff;
   logic                  sky_hit_ff;
   logic [COORD_BITS-1:0] row_ff, col_ff, sr_ff, sc_ff;
   logic [7:0]            blue_ff, green_ff, red_ff;
   logic [STEP_W-1:0]     dr_ff, dc_ff, rr_ff, rc_ff;

   // arithmetic
   logic signed [ACC_W-1:0] x_acc_ff, y_acc_ff, w_acc_ff;
   logic [ACC_W-1:0]        ud_ff, rem_ff;
   logic [QUOT_W-1:0]       sh_ff, q_ff;
   logic                    neg_ff, ovf_ff, bad_ff;
   logic signed [OUT_W-1:0] gx_ff, gy_ff;
   logic [SQ_W-1:0]         d2_ff;
   logic [LIM_W-1:0]        lim_ff;

   // output register
   logic                    out_v_ff;
   logic signed [OUT_W-1:0] ox_ff, oy_ff;
   logic [7:0]              or_ff, og_ff, ob_ff;

   logic [STEP_W-1:0]       rstep, cstep;
   logic [STEP_W:0]         mt_r, mt_c;
   logic signed [COEF_W-1:0]  ma;
   logic signed [MUL_B_W-1:0] mb;
   logic signed [PROD_W-1:0]  prod;
   logic signed [ACC_W-1:0] num;
   logic [ACC_W-1:0]        un, ud;
   logic [ACC_W:0]          dt, dd;
   logic                    dge;
   logic [OUT_W-1:0]        qres;
   logic                    qbad;
   logic [MUL_B_W-1:0]      coord_ext_c, coord_ext_r;

   assign rstep = (steps_ff[3:0] == '0) ? STEP_W'(1) : steps_ff[3:0];
   assign cstep = (steps_ff[7:4] == '0) ? STEP_W'(1) : steps_ff[7:4];
   assign mt_r  = {rr_ff, sr_ff[COORD_BITS-1]};
   assign mt_c  = {rc_ff, sc_ff[COORD_BITS-1]};

   assign coord_ext_c = {{(MUL_B_W-COORD_BITS){1'b0}}, col_ff};
   assign coord_ext_r = {{(MUL_B_W-COORD_BITS){1'b0}}, row_ff};

   // one shared signed multiplier
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (cmd.op)
         OP_MUL: begin
            unique case (cmd.idx)
               3'd0:    begin ma = coef_a_ff[31:0];  mb = coord_ext_c; end
               3'd1:    begin ma = coef_a_ff[63:32]; mb = coord_ext_r; end
               3'd2:    begin ma = coef_b_ff[63:32]; mb = coord_ext_c; end
               3'd3:    begin ma = coef_c_ff[31:0];  mb = coord_ext_r; end
               3'd4:    begin ma = coef_d_ff[31:0];  mb = coord_ext_c; end
               default: begin ma = coef_d_ff[63:32]; mb = coord_ext_r; end
            endcase
         end
         OP_SQ: begin
            unique case (cmd.idx)
               3'd0: begin
                  ma = COEF_W'(gx_ff);
                  mb = MUL_B_W'(gx_ff);
               end
               3'd1: begin
                  ma = COEF_W'(gy_ff);
                  mb = MUL_B_W'(gy_ff);
               end
               default: begin
                  ma = {{(COEF_W-23){1'b0}}, range_ff};
                  mb = {{(MUL_B_W-23){1'b0}}, range_ff};
               end
            endcase
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end
   assign prod = PROD_W'(ma) * PROD_W'(mb);

   // divider operands
   assign num = cmd.sel_y ? y_acc_ff : x_acc_ff;
   assign un  = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
   assign ud  = w_acc_ff[ACC_W-1] ? ACC_W'(-w_acc_ff) : ACC_W'(w_acc_ff);
   assign dt  = {rem_ff, sh_ff[QUOT_W-1]};
   assign dge = dt >= {1'b0, ud_ff};
   assign dd  = dt - {1'b0, ud_ff};

   always_comb begin
      if (neg_ff) begin
         qbad = ovf_ff || (q_ff > QUOT_W'(1 << (OUT_W-1)));
         qres = OUT_W'(-q_ff);
      end else begin
         qbad = ovf_ff || (q_ff > QUOT_W'((1 << (OUT_W-1)) - 1));
         qres = q_ff[OUT_W-1:0];
      end
   end

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= 64'd1048576;
         coef_b_ff <= 64'd0;
         coef_c_ff <= 64'd1048576;
         coef_d_ff <= 64'd0;
         coef_l_ff <= 32'd1048576;
         sky_ff    <= 8'd178;
         range_ff  <= 23'd524288;
         steps_ff  <= 8'd33;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_COEF_A: coef_a_ff <= csr_data;
            REG_COEF_B: coef_b_ff <= csr_data;
            REG_COEF_C: coef_c_ff <= csr_data;
            REG_COEF_D: coef_d_ff <= csr_data;
            REG_COEF_L: coef_l_ff <= csr_data[31:0];
            REG_SKY:    sky_ff    <= csr_data[7:0];
            REG_RANGE:  range_ff  <= csr_data[22:0];
            default:    steps_ff  <= csr_data[7:0];
         endcase
      end
   end

   // control state: row tracking, sky flag, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         last_row_ff <= '0;
         sky_hit_ff  <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         if (cmd.op == OP_LOAD) begin
            last_row_ff <= pix_row;
            if (pix_row != last_row_ff) sky_hit_ff <= 1'b0;
         end else if (cmd.op == OP_SKYSET) begin
            sky_hit_ff <= 1'b1;
         end
         if (cmd.op == OP_EMIT) out_v_ff <= 1'b1;
         else if (rsp_ready)    out_v_ff <= 1'b0;
      end
   end

   // payload and arithmetic registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            row_ff   <= pix_row;
            col_ff   <= pix_col;
            sr_ff    <= pix_row;
            sc_ff    <= pix_col;
            blue_ff  <= pix_blue;
            green_ff <= pix_green;
            red_ff   <= pix_red;
            dr_ff    <= rstep;
            dc_ff    <= cstep;
            rr_ff    <= '0;
            rc_ff    <= '0;
            x_acc_ff <= ACC_W'($signed(coef_b_ff[31:0]));
            y_acc_ff <= ACC_W'($signed(coef_c_ff[63:32]));
            w_acc_ff <= ACC_W'($signed(coef_l_ff));
            bad_ff   <= 1'b0;
         end
         OP_MOD: begin
            sr_ff <= sr_ff << 1;
            sc_ff <= sc_ff << 1;
            rr_ff <= (mt_r >= {1'b0, dr_ff}) ? STEP_W'(mt_r - {1'b0, dr_ff}) : STEP_W'(mt_r);
            rc_ff <= (mt_c >= {1'b0, dc_ff}) ? STEP_W'(mt_c - {1'b0, dc_ff}) : STEP_W'(mt_c);
         end
         OP_MUL: begin
            if (cmd.idx < 3'd2)      x_acc_ff <= x_acc_ff + prod[ACC_W-1:0];
            else if (cmd.idx < 3'd4) y_acc_ff <= y_acc_ff + prod[ACC_W-1:0];
            else                     w_acc_ff <= w_acc_ff + prod[ACC_W-1:0];
         end
         OP_DIVINIT: begin
            ud_ff  <= ud;
            rem_ff <= un >> DIV_PRE;
            sh_ff  <= {un[DIV_PRE-1:0], 16'b0};
            q_ff   <= '0;
            neg_ff <= num[ACC_W-1] ^ w_acc_ff[ACC_W-1];
            ovf_ff <= {{DIV_PRE{1'b0}}, un} >= {ud, {DIV_PRE{1'b0}}};
         end
         OP_DIV: begin
            sh_ff  <= sh_ff << 1;
            q_ff   <= {q_ff[QUOT_W-2:0], dge};
            rem_ff <= dge ? dd[ACC_W-1:0] : dt[ACC_W-1:0];
         end
         OP_DIVEND: begin
            if (cmd.sel_y) gy_ff <= qres;
            else           gx_ff <= qres;
            bad_ff <= bad_ff | qbad;
         end
         OP_SQ: begin
            unique case (cmd.idx)
               3'd0:    d2_ff  <= prod[SQ_W-1:0];
               3'd1:    d2_ff  <= d2_ff + prod[SQ_W-1:0];
               default: lim_ff <= prod[LIM_W-1:0];
            endcase
         end
         OP_EMIT: begin
            ox_ff <= gx_ff;
            oy_ff <= gy_ff;
            or_ff <= red_ff;
            og_ff <= green_ff;
            ob_ff <= blue_ff;
         end
         default: begin
         end
      endcase
   end

   assign stat.on_grid  = (rr_ff == '0) && (rc_ff == '0);
   assign stat.sky_hit  = sky_hit_ff;
   assign stat.is_sky   = blue_ff == sky_ff;
   assign stat.w_zero   = w_acc_ff == '0;
   assign stat.quot_bad = bad_ff;
   assign stat.dist_ok  = d2_ff <= {{(SQ_W-LIM_W){1'b0}}, lim_ff};
   assign stat.out_busy = out_v_ff && !rsp_ready;

   assign rsp_valid    = out_v_ff;
   assign rsp_ground_x = ox_ff;
   assign rsp_ground_y = oy_ff;
   assign rsp_red      = or_ff;
   assign rsp_green    = og_ff;
   assign rsp_blue     = ob_ff;

endmodule

FILE: design/ipm_control.sv
// sequencer that steps one pixel word through the datapath
module ipm_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   output ipm_pkg::cmd_type   cmd,
   input  ipm_pkg::stat_type  stat
);
   import ipm_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MOD   = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_ZCHK  = 4'd4;
   localparam logic [3:0] S_DINIT = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_DEND  = 4'd7;
   localparam logic [3:0] S_QCHK  = 4'd8;
   localparam logic [3:0] S_SQ    = 4'd9;
   localparam logic [3:0] S_DCMP  = 4'd10;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             sel_ff, sel_in;

   assign in_ready = state_ff == S_IDLE;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      sel_in    = sel_ff;
      cmd.op    = OP_NONE;
      cmd.idx   = cnt_ff[2:0];
      cmd.sel_y = sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.op   = OP_LOAD;
               cnt_in   = '0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.op = OP_MOD;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(COORD_BITS - 1)) state_in = S_CHECK;
         end
         S_CHECK: begin
            cnt_in = '0;
            priority if (!stat.on_grid || stat.sky_hit) begin
               state_in = S_IDLE;
            end else if (stat.is_sky) begin
               cmd.op   = OP_SKYSET;
               state_in = S_IDLE;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.op = OP_MUL;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(5)) state_in = S_ZCHK;
         end
         S_ZCHK: begin
            sel_in   = 1'b0;
            state_in = stat.w_zero ? S_IDLE : S_DINIT;
         end
         S_DINIT: begin
            cmd.op   = OP_DIVINIT;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUOT_W - 1)) state_in = S_DEND;
         end
         S_DEND: begin
            cmd.op = OP_DIVEND;
            if (sel_ff) begin
               state_in = S_QCHK;
            end else begin
               sel_in   = 1'b1;
               state_in = S_DINIT;
            end
         end
         S_QCHK: begin
            cnt_in   = '0;
            state_in = stat.quot_bad ? S_IDLE : S_SQ;
         end
         S_SQ: begin
            cmd.op = OP_SQ;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(2)) state_in = S_DCMP;
         end
         S_DCMP: begin
            priority if (!stat.dist_ok) begin
               state_in = S_IDLE;
            end else if (!stat.out_busy) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end else begin
               state_in = S_DCMP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

FILE: design/ipm_pixel_to_ground_point.sv
// top level: maps sampled camera pixels through a homography onto ground points
// ipm_pixel_to_ground_point takes one pixel word (row, column, rgb) at a time and
// returns at most one ground point word (x, y in signed q7.16 metres, plus the
// pixel colour). a word is taken only while the sequencer is idle. an off-grid
// pixel, a pixel in a row already ended by sky, or a sky pixel stops after the
// 12 grid remainder steps, one with a zero denominator after the 6 shared
// multiplier passes; a mapped pixel also runs two 25-step restoring divides
// and 3 squaring passes, plus any wait for a free output register. the
// result sits in its own register, so the next pixel is taken while the
// previous point still waits. register writes are always accepted and must
// only be issued while no pixel is in flight.
module ipm_pixel_to_ground_point (
   input  logic          clock,
   input  logic          reset,
   ipm_req_if.sink       req,
   ipm_rsp_if.source     rsp,
   ipm_csr_if.sink       csr
);
   import ipm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // register port never stalls
   assign csr.ready = 1'b1;

   // sequencer: grid check, sky handling, arithmetic order
   ipm_control u_control (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .cmd      (cmd),
      .stat     (stat)
   );

   // datapath: config, shared multiplier, divider, output register
   ipm_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .pix_row      (req.pix_row),
      .pix_col      (req.pix_col),
      .pix_blue     (req.pix_blue),
      .pix_green    (req.pix_green),
      .pix_red      (req.pix_red),
      .csr_valid    (csr.valid),
      .csr_index    (csr.index),
      .csr_data     (csr.data),
      .rsp_valid    (rsp.valid),
      .rsp_ready    (rsp.ready),
      .rsp_ground_x (rsp.ground_x),
      .rsp_ground_y (rsp.ground_y),
      .rsp_red      (rsp.out_red),
      .rsp_green    (rsp.out_green),
      .rsp_blue     (rsp.out_blue)
   );

endmodule

FILE: dv/tb_top.sv
// testbench for the pixel to ground point mapper: prediction, stimulus and checks
module tb_top;
   import ipm_pkg::*;

   localparam int  N_PHASES     = 9;
   localparam int  PHASE_WORDS  = 90;
   localparam int  SETTLE_CYC   = 120;   // long enough for a mapped pixel to finish
   localparam int  LONG_HOLD    = 700;
   localparam int  CYCLE_LIMIT  = 1000000;

   typedef struct {
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
      logic [7:0]            blue, green, red;
   } pixel_t;

   typedef struct {
      logic signed [OUT_W-1:0] gx, gy;
      logic [7:0]              red, green, blue;
   } point_t;

   // ground point predictor with its own register copy and row state
   class ground_sb;
      logic [63:0] regs [8];
      bit          sky_seen;
      logic [COORD_BITS-1:0] prev_row;
      point_t      points [$];
      int          errors;

      function new();
         regs[REG_COEF_A] = 64'd1048576;
         regs[REG_COEF_B] = 64'd0;
         regs[REG_COEF_C] = 64'd1048576;
         regs[REG_COEF_D] = 64'd0;
         regs[REG_COEF_L] = 64'd1048576;
         regs[REG_SKY]    = 64'd178;
         regs[REG_RANGE]  = 64'd524288;
         regs[REG_STEPS]  = 64'd33;
         sky_seen = 0;
         prev_row = '0;
         errors   = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] d);
         case (idx)
            REG_COEF_L: regs[idx] = {32'd0, d[31:0]};
            REG_SKY:    regs[idx] = {56'd0, d[7:0]};
            REG_RANGE:  regs[idx] = {41'd0, d[22:0]};
            REG_STEPS:  regs[idx] = {56'd0, d[7:0]};
            default:    regs[idx] = d;
         endcase
      endfunction

      function longint coef(int i, bit hi);
         logic [31:0] w;
         w = hi ? regs[i][63:32] : regs[i][31:0];
         return longint'($signed(w));
      endfunction

      // q7.16 quotient truncated toward zero, 0 on overflow or zero divisor
      function bit q16_div(longint num, longint den, output longint res);
         longint unsigned un, ud, q, rem, mag;
         bit neg;
         un  = (num < 0) ? -num : num;
         ud  = (den < 0) ? -den : den;
         neg = (num < 0) != (den < 0);
         res = 0;
         if (ud == 0) return 0;
         q = un / ud;
         if (q > 255) return 0;
         rem = un - q * ud;
         mag = (q << 16) | ((rem << 16) / ud);
         if (neg) begin
            if (mag > 64'd8388608) return 0;
            res = -longint'(mag);
         end else begin
            if (mag > 64'd8388607) return 0;
            res = longint'(mag);
         end
         return 1;
      endfunction

      function void note_pixel(pixel_t p);
         int unsigned rstep, cstep;
         longint c, r, xn, yn, wd, x, y, d2, lim;
         point_t pt;
         if (p.row != prev_row) sky_seen = 0;
         prev_row = p.row;
         rstep = regs[REG_STEPS][3:0];
         cstep = regs[REG_STEPS][7:4];
         if (rstep == 0) rstep = 1;
         if (cstep == 0) cstep = 1;
         if ((p.row % rstep) != 0 || (p.col % cstep) != 0) return;
         if (sky_seen) return;
         if (p.blue == regs[REG_SKY][7:0]) begin
            sky_seen = 1;
            return;
         end
         c  = p.col;
         r  = p.row;
         xn = coef(REG_COEF_A, 0) * c + coef(REG_COEF_A, 1) * r + coef(REG_COEF_B, 0);
         yn = coef(REG_COEF_B, 1) * c + coef(REG_COEF_C, 0) * r + coef(REG_COEF_C, 1);
         wd = coef(REG_COEF_D, 0) * c + coef(REG_COEF_D, 1) * r + coef(REG_COEF_L, 0);
         if (wd == 0) return;
         if (!q16_div(xn, wd, x) || !q16_div(yn, wd, y)) return;
         d2  = x * x + y * y;
         lim = longint'(regs[REG_RANGE]) * longint'(regs[REG_RANGE]);
         if (d2 > lim) return;
         pt.gx    = x[OUT_W-1:0];
         pt.gy    = y[OUT_W-1:0];
         pt.red   = p.red;
         pt.green = p.green;
         pt.blue  = p.blue;
         points = {points, pt};
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) $display("mismatch: %s", msg);
      endtask

      task check_point(point_t got);
         point_t exp_pt;
         if (points.size() == 0) begin
            report($sformatf("unexpected point x=%0d y=%0d", got.gx, got.gy));
            return;
         end
         exp_pt = points.pop_front();
         if (got.gx !== exp_pt.gx)
            report($sformatf("ground_x got %0d want %0d", got.gx, exp_pt.gx));
         if (got.gy !== exp_pt.gy)
            report($sformatf("ground_y got %0d want %0d", got.gy, exp_pt.gy));
         if (got.red !== exp_pt.red || got.green !== exp_pt.green ||
             got.blue !== exp_pt.blue)
            report($sformatf("colour got %h%h%h want %h%h%h", got.red, got.green,
                             got.blue, exp_pt.red, exp_pt.green, exp_pt.blue));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   int   cycles = 0;
   bit   hold_pending = 0;
   ground_sb sb = new();

   ipm_req_if req ();
   ipm_rsp_if rsp ();
   ipm_csr_if csr ();

   ipm_pixel_to_ground_point u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   always #2 clock = ~clock;

   // watchdog on total run length
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** ipm_pixel_to_ground_point: FAILED **");
         $finish;
      end
   end

   // receiver: randomly changing stall pattern, plus one long hold-off
   initial begin
      int mode, hold_left;
      rsp.ready = 0;
      mode = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (cycles % 64 == 0) mode = $urandom_range(0, 3);
         if (hold_pending) begin
            hold_pending = 0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 0;
         end else begin
            case (mode)
               0, 1:    rsp.ready <= 1;
               2:       rsp.ready <= $urandom_range(0, 1);
               default: rsp.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // sample accepted points at the falling edge before the rising edge that takes them
   always @(negedge clock) begin
      point_t got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.gx    = rsp.ground_x;
         got.gy    = rsp.ground_y;
         got.red   = rsp.out_red;
         got.green = rsp.out_green;
         got.blue  = rsp.out_blue;
         sb.check_point(got);
      end
   end

   // one register write word; caller lowers valid after the last one
   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [63:0] d);
      csr.valid <= 1;
      csr.index <= idx;
      csr.data  <= d;
      do @(negedge clock); while (!csr.ready);
      sb.write_reg(idx, d);
      @(posedge clock);
   endtask

   // one pixel word; valid stays high for a following word
   task send_pixel(pixel_t p);
      req.valid     <= 1;
      req.pix_row   <= p.row;
      req.pix_col   <= p.col;
      req.pix_blue  <= p.blue;
      req.pix_green <= p.green;
      req.pix_red   <= p.red;
      do @(negedge clock); while (!req.ready);
      sb.note_pixel(p);
      @(posedge clock);
   endtask

   task idle_req(int n);
      req.valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   // drain expected points, then give an in-flight pixel time to finish
   task drain;
      idle_req(1);
      while (sb.points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   function int srnd(int unsigned mag);
      return int'($urandom_range(0, 2 * mag)) - int'(mag);
   endfunction

   function pixel_t mk_pix(int row, int col, int blue);
      pixel_t p;
      p.row   = COORD_BITS'(row);
      p.col   = COORD_BITS'(col);
      p.blue  = 8'(blue);
      p.green = 8'($urandom);
      p.red   = 8'($urandom);
      return p;
   endfunction

   // load one full register setting of the given flavor
   task load_setting(int kind);
      logic [31:0] h [9];
      logic [63:0] rng, steps, sky;
      case (kind)
         0: begin  // all coefficients minus one ulp: x = y = 1.0
            foreach (h[i]) h[i] = 32'hFFFF_FFFF;
         end
         1: begin  // signed extremes
            foreach (h[i]) h[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
         2: begin  // denominator crosses zero along the row
            h = '{32'h0010_0000, 0, 0, 0, 32'h0010_0000, 0, 32'h0010_0000, 0, 0};
            h[8] = -32'sd20 * 32'sh0010_0000;
         end
         3: begin  // fully random
            foreach (h[i]) h[i] = $urandom;
         end
         default: begin  // plausible camera-like perspective
            h[0] = srnd(1 << 21); h[1] = srnd(1 << 18); h[2] = srnd(1 << 28);
            h[3] = srnd(1 << 18); h[4] = srnd(1 << 21); h[5] = srnd(1 << 28);
            h[6] = srnd(1 << 12); h[7] = srnd(1 << 12);
            h[8] = $urandom_range(1 << 26, 1 << 29);
            if ($urandom_range(0, 3) == 0) h[8] = -h[8];
         end
      endcase
      case ($urandom_range(0, 4))
         0:       rng = 0;
         1:       rng = 23'h7F_FFFF;
         default: rng = $urandom_range(0, 23'h7F_FFFF);
      endcase
      case ($urandom_range(0, 3))
         0:       steps = 0;
         1:       steps = 8'hFF;
         2:       steps = $urandom_range(0, 255);
         default: steps = {56'd0, 4'($urandom_range(0, 2)), 4'($urandom_range(0, 2))};
      endcase
      sky = $urandom_range(0, 2) == 0 ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                      : $urandom_range(0, 255);
      write_csr(REG_COEF_A, {h[1], h[0]});
      write_csr(REG_COEF_B, {h[3], h[2]});
      write_csr(REG_COEF_C, {h[5], h[4]});
      write_csr(REG_COEF_D, {h[7], h[6]});
      write_csr(REG_COEF_L, {$urandom, h[8]});
      write_csr(REG_SKY, {$urandom, $urandom} & ~64'hFF | sky);
      write_csr(REG_RANGE, {$urandom, 9'd0, rng[22:0]});
      write_csr(REG_STEPS, steps);
      csr.valid <= 0;
      @(posedge clock);
   endtask

   // raster runs with random colours, sky pixels and some noise words
   task run_phase(int words, bit long_hold);
      int sent, row, col, run_len, burst;
      logic [7:0] sky;
      sent  = 0;
      burst = $urandom_range(1, 20);
      sky   = sb.regs[REG_SKY][7:0];
      while (sent < words) begin
         row = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 120);
         col = $urandom_range(0, 2) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 40);
         run_len = $urandom_range(3, 24);
         for (int k = 0; k < run_len && sent < words; k++) begin
            if ($urandom_range(0, 9) == 0)
               send_pixel(mk_pix($urandom, $urandom, $urandom));
            else
               send_pixel(mk_pix(row, (col + k) & 12'hFFF,
                                 $urandom_range(0, 11) == 0 ? sky : $urandom_range(0, 255)));
            sent++;
            if (long_hold && sent == 5) hold_pending = 1;
            if (--burst == 0) begin
               burst = $urandom_range(1, 20);
               if ($urandom_range(0, 3) != 0) idle_req($urandom_range(1, 15));
            end
         end
      end
   endtask

   initial begin
      req.valid = 0; req.pix_row = 0; req.pix_col = 0;
      req.pix_blue = 0; req.pix_green = 0; req.pix_red = 0;
      csr.valid = 0; csr.index = REG_COEF_A; csr.data = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset setting: identity map, range 8.0, every second column
      send_pixel(mk_pix(0, 0, 8'h00));        // origin
      send_pixel(mk_pix(0, 1, 8'h11));        // off grid column
      send_pixel(mk_pix(0, 8, 8'hFF));        // exactly at the range limit
      send_pixel(mk_pix(0, 10, 8'h20));       // beyond range
      send_pixel(mk_pix(3, 2, 8'h30));        // row change
      send_pixel(mk_pix(3, 4, 8'd178));       // sky ends the row
      send_pixel(mk_pix(3, 6, 8'h01));        // suppressed by sky
      send_pixel(mk_pix(4, 2, 8'd178 ^ 8'h01)); // new row clears sky
      send_pixel(mk_pix(4, 300, 8'h02));      // quotient overflow
      send_pixel(mk_pix(4095, 4094, 8'hFF));  // coordinate extremes
      send_pixel(mk_pix(4095, 4095, 8'h00));
      drain();

      // zero-crossing denominator: zero divisor, negative and positive quotients
      load_setting(2);
      for (int c = 16; c <= 24; c += 2) send_pixel(mk_pix(1, c, c));
      drain();

      for (int ph = 0; ph < N_PHASES; ph++) begin
         load_setting(ph < 4 ? ph : 4 + ph % 2);
         run_phase(PHASE_WORDS, ph == 5);
         drain();
      end

      if (sb.errors == 0)
         $display("** ipm_pixel_to_ground_point: PASSED **");
      else
         $display("** ipm_pixel_to_ground_point: FAILED **");
      $finish;
   end

endmodule
